// ----- src/flbss_pkg.sv -----
// Package for the fill-level bucketed sparse set.
// Holds the channel word types, operation and bucket codes, and the
// command/status structs shared by the controller and the datapath.
`default_nettype none
package flbss_pkg;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  slot_id;
    logic [3:0]  fill_count;
    logic [3:0]  size_lo;
    logic [3:0]  size_hi;
    logic [11:0] rank;
  } cmd_word_t;

  typedef struct packed {
    logic       found;
    logic [7:0] result_slot;
    logic [3:0] item_position;
    logic [8:0] range_count;
  } res_word_t;

  localparam logic [2:0] KIND_INSERT   = 3'd0;
  localparam logic [2:0] KIND_REMOVE   = 3'd1;
  localparam logic [2:0] KIND_COUNT    = 3'd2;
  localparam logic [2:0] KIND_NTH_SLOT = 3'd3;
  localparam logic [2:0] KIND_NTH_ITEM = 3'd4;

  localparam logic [1:0] BK_EMPTY = 2'd0;
  localparam logic [1:0] BK_FULL  = 2'd1;
  localparam logic [1:0] BK_ONE   = 2'd2;
  localparam logic [1:0] BK_MULTI = 2'd3;

  localparam logic [2:0] ADDR_MAX_FILL  = 3'd0;
  localparam logic [3:0] MAX_FILL_RESET = 4'd4;

  typedef struct packed {
    logic idle;
    logic load;
    logic clr_step;
    logic pos_rd;
    logic chk_step;
    logic ins_wr;
    logic last_rd;
    logic rem_wr;
    logic cnt_calc;
    logic nth_calc;
    logic item_calc;
    logic div_step;
    logic full_rd;
    logic get;
    logic wl_rd;
    logic wf_rd;
    logic wc_step;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_insert;
    logic chk_last;
    logic rem_ok;
    logic nth_hit;
    logic item_full;
    logic item_one;
    logic multi_any;
    logic div_last;
    logic walk_hit;
    logic walk_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- src/flbss_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module flbss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ----- src/flbss_ctrl.sv -----
// Controller state machine for the bucketed sparse set.
// Depends on flbss_pkg for the command and status structs.
`default_nettype none
module flbss_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  input  wire logic [2:0]          cmd_kind,
  input  wire flbss_pkg::dp_stat_t stat,
  output flbss_pkg::ctl_cmd_t      ctl
);
  import flbss_pkg::*;

  typedef enum logic [16:0] {
    S_CLEAR = 17'b00000000000000001,
    S_IDLE  = 17'b00000000000000010,
    S_POS   = 17'b00000000000000100,
    S_CHK   = 17'b00000000000001000,
    S_INS   = 17'b00000000000010000,
    S_RLAST = 17'b00000000000100000,
    S_RWR   = 17'b00000000001000000,
    S_CNT   = 17'b00000000010000000,
    S_NTH   = 17'b00000000100000000,
    S_ITEM  = 17'b00000001000000000,
    S_DIV   = 17'b00000010000000000,
    S_FRD   = 17'b00000100000000000,
    S_GET   = 17'b00001000000000000,
    S_WL    = 17'b00010000000000000,
    S_WF    = 17'b00100000000000000,
    S_WC    = 17'b01000000000000000,
    S_DONE  = 17'b10000000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        ctl.idle = 1'b1;
        if (cmd_valid) begin
          ctl.load = 1'b1;
          unique case (cmd_kind) inside
            KIND_INSERT, KIND_REMOVE: state_next = S_POS;
            KIND_COUNT:               state_next = S_CNT;
            KIND_NTH_SLOT:            state_next = S_NTH;
            KIND_NTH_ITEM:            state_next = S_ITEM;
            default:                  state_next = S_DONE;
          endcase
        end
      end
      S_POS: begin
        ctl.pos_rd = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        ctl.chk_step = 1'b1;
        if (stat.chk_last) begin
          if (stat.is_insert)   state_next = S_INS;
          else if (stat.rem_ok) state_next = S_RLAST;
          else                  state_next = S_DONE;
        end
      end
      S_INS: begin
        ctl.ins_wr = 1'b1;
        state_next = S_DONE;
      end
      S_RLAST: begin
        ctl.last_rd = 1'b1;
        state_next = S_RWR;
      end
      S_RWR: begin
        ctl.rem_wr = 1'b1;
        state_next = S_DONE;
      end
      S_CNT: begin
        ctl.cnt_calc = 1'b1;
        state_next = S_DONE;
      end
      S_NTH: begin
        ctl.nth_calc = 1'b1;
        state_next = stat.nth_hit ? S_GET : S_DONE;
      end
      S_ITEM: begin
        ctl.item_calc = 1'b1;
        if (stat.item_full)      state_next = S_DIV;
        else if (stat.item_one)  state_next = S_GET;
        else if (stat.multi_any) state_next = S_WL;
        else                     state_next = S_DONE;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (stat.div_last) state_next = S_FRD;
      end
      S_FRD: begin
        ctl.full_rd = 1'b1;
        state_next = S_GET;
      end
      S_GET: begin
        ctl.get = 1'b1;
        state_next = S_DONE;
      end
      S_WL: begin
        ctl.wl_rd = 1'b1;
        state_next = S_WF;
      end
      S_WF: begin
        ctl.wf_rd = 1'b1;
        state_next = S_WC;
      end
      S_WC: begin
        ctl.wc_step = 1'b1;
        if (stat.walk_hit || stat.walk_last) state_next = S_DONE;
        else                                 state_next = S_WL;
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end
endmodule
`default_nettype wire

// ----- src/flbss_dp.sv -----
// Datapath of the bucketed sparse set: member lists, positions, fills,
// bucket sizes, divider, list walk and result register.
// Depends on flbss_pkg and flbss_ram.
`default_nettype none
module flbss_dp #(
  parameter int NUM_SLOTS = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire flbss_pkg::ctl_cmd_t  ctl,
  input  wire flbss_pkg::cmd_word_t cmd,
  input  wire logic [3:0]           max_fill,
  input  wire logic                 res_stall,
  output logic                      res_valid,
  output flbss_pkg::res_word_t      res,
  output flbss_pkg::dp_stat_t       stat
);
  import flbss_pkg::*;

  localparam int IW  = $clog2(NUM_SLOTS);
  localparam int SW  = $clog2(NUM_SLOTS + 1);
  localparam int CTW = (SW > 4) ? SW : 4;
  localparam int NW  = (SW + 4 > 13) ? SW + 4 : 13;
  localparam int LD  = 4 * (2 ** IW);

  cmd_word_t        cw;
  logic [SW-1:0]    size_q [4];
  logic [CTW-1:0]   step;
  logic [3:0]       hold;
  logic             found_r;
  logic [7:0]       slot_r;
  logic [3:0]       ipos_r;
  logic [8:0]       cnt_r;
  logic [11:0]      walk_n;
  logic [IW-1:0]    walk_s;
  logic [11:0]      quo;
  logic [3:0]       rem;

  logic             list_we, list_re, mpos_we, fill_we;
  logic [IW+1:0]    list_waddr, list_raddr;
  logic [IW-1:0]    list_wdata, list_rd;
  logic [IW-1:0]    mpos_waddr, mpos_wdata, mpos_rd;
  logic [3:0]       fill_rd;

  logic [IW-1:0]    s_idx, pos;
  logic             slot_ok;
  logic [1:0]       bsel, pk;
  logic             chk_hit;
  logic [3:0]       inc;
  logic             rng_ok, ins_ok;
  logic [NW-1:0]    rk, full_items, n1, n2, acc, cnt_sum;
  logic             nth_hit;
  logic [1:0]       nth_b;
  logic [IW-1:0]    nth_idx;
  logic [4:0]       div_t;
  logic             div_ge;
  logic [SW-1:0]    size_b;

  flbss_ram #(.WIDTH(IW), .DEPTH(LD)) u_lists (
    .clk(clk), .wr_en(list_we), .wr_addr(list_waddr), .wr_data(list_wdata),
    .rd_en(list_re), .rd_addr(list_raddr), .rd_data(list_rd)
  );

  flbss_ram #(.WIDTH(IW), .DEPTH(2 ** IW)) u_mpos (
    .clk(clk), .wr_en(mpos_we), .wr_addr(mpos_waddr), .wr_data(mpos_wdata),
    .rd_en(ctl.pos_rd), .rd_addr(s_idx), .rd_data(mpos_rd)
  );

  flbss_ram #(.WIDTH(4), .DEPTH(2 ** IW)) u_fill (
    .clk(clk), .wr_en(fill_we), .wr_addr(s_idx), .wr_data(cw.fill_count),
    .rd_en(ctl.wf_rd), .rd_addr(list_rd), .rd_data(fill_rd)
  );

  assign s_idx   = IW'(cw.slot_id);
  assign pos     = mpos_rd;
  assign slot_ok = int'(cw.slot_id) < NUM_SLOTS;
  assign pk      = 2'(step - 1'b1);
  assign chk_hit = (SW'(pos) < size_q[pk]) && (list_rd == s_idx);

  always_comb begin
    if (cw.fill_count == 4'd0)          bsel = BK_EMPTY;
    else if (cw.fill_count == max_fill) bsel = BK_FULL;
    else if (cw.fill_count == 4'd1)     bsel = BK_ONE;
    else                                bsel = BK_MULTI;
  end

  assign size_b = size_q[bsel];
  assign ins_ok = slot_ok && (hold == 4'd0) && (size_b < SW'(NUM_SLOTS));

  assign rng_ok        = cw.size_lo <= cw.size_hi;
  assign inc[BK_EMPTY] = rng_ok && (cw.size_lo == 4'd0);
  assign inc[BK_FULL]  = rng_ok && (cw.size_hi >= max_fill);
  assign inc[BK_ONE]   = rng_ok && (cw.size_lo <= 4'd1) && (cw.size_hi >= 4'd1) &&
                         (max_fill != 4'd1);
  assign inc[BK_MULTI] = rng_ok && (cw.size_lo <= 4'd2) && (cw.size_hi >= 4'd2) &&
                         (max_fill > 4'd2);

  assign rk         = NW'(cw.rank);
  assign full_items = NW'(size_q[BK_FULL]) * NW'(max_fill);
  assign n1         = rk - full_items;
  assign n2         = n1 - NW'(size_q[BK_ONE]);

  always_comb begin
    cnt_sum = '0;
    for (int b = 0; b < 4; b++) begin
      if (inc[b]) cnt_sum = cnt_sum + NW'(size_q[b]);
    end
  end

  always_comb begin
    acc     = '0;
    nth_hit = 1'b0;
    nth_b   = BK_EMPTY;
    nth_idx = '0;
    for (int b = 0; b < 4; b++) begin
      if (inc[b] && !nth_hit) begin
        if (rk < acc + NW'(size_q[b])) begin
          nth_hit = 1'b1;
          nth_b   = 2'(b);
          nth_idx = IW'(rk - acc);
        end else begin
          acc = acc + NW'(size_q[b]);
        end
      end
    end
  end

  assign div_t  = {rem, quo[11]};
  assign div_ge = div_t >= {1'b0, max_fill};

  always_comb begin
    list_re    = 1'b1;
    list_raddr = '0;
    if (ctl.chk_step)       list_raddr = {step[1:0], pos};
    else if (ctl.last_rd)   list_raddr = {bsel, IW'(size_b - 1'b1)};
    else if (ctl.nth_calc)  list_raddr = {nth_b, nth_idx};
    else if (ctl.item_calc) list_raddr = {BK_ONE, IW'(n1)};
    else if (ctl.full_rd)   list_raddr = {BK_FULL, IW'(quo)};
    else if (ctl.wl_rd)     list_raddr = {BK_MULTI, step[IW-1:0]};
    else                    list_re = 1'b0;
    if (ctl.chk_step && step == CTW'(4)) list_re = 1'b0;
  end

  always_comb begin
    list_we    = 1'b0;
    list_waddr = '0;
    list_wdata = '0;
    mpos_we    = 1'b0;
    mpos_waddr = '0;
    mpos_wdata = '0;
    fill_we    = 1'b0;
    if (ctl.clr_step) begin
      list_we    = 1'b1;
      list_waddr = {BK_EMPTY, step[IW-1:0]};
      list_wdata = step[IW-1:0];
      mpos_we    = 1'b1;
      mpos_waddr = step[IW-1:0];
      mpos_wdata = step[IW-1:0];
    end else if (ctl.ins_wr && ins_ok) begin
      list_we    = 1'b1;
      list_waddr = {bsel, size_b[IW-1:0]};
      list_wdata = s_idx;
      mpos_we    = 1'b1;
      mpos_waddr = s_idx;
      mpos_wdata = size_b[IW-1:0];
      fill_we    = 1'b1;
    end else if (ctl.rem_wr) begin
      list_we    = 1'b1;
      list_waddr = {bsel, pos};
      list_wdata = list_rd;
      mpos_we    = 1'b1;
      mpos_waddr = list_rd;
      mpos_wdata = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      res_valid <= 1'b0;
      size_q[BK_EMPTY] <= SW'(NUM_SLOTS);
      size_q[BK_FULL]  <= '0;
      size_q[BK_ONE]   <= '0;
      size_q[BK_MULTI] <= '0;
    end else begin
      if (ctl.clr_step || ctl.chk_step || ctl.div_step) step <= step + 1'b1;
      if (ctl.load || ctl.item_calc) step <= '0;
      if (ctl.wc_step && !stat.walk_hit) step <= step + 1'b1;
      if (ctl.ins_wr && ins_ok) size_q[bsel] <= size_b + 1'b1;
      if (ctl.rem_wr) size_q[bsel] <= size_b - 1'b1;
      if (ctl.finish) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cw      <= cmd;
      hold    <= '0;
      found_r <= 1'b0;
      slot_r  <= '0;
      ipos_r  <= '0;
      cnt_r   <= '0;
    end
    if (ctl.chk_step && step != '0) begin
      hold[pk] <= chk_hit;
    end
    if (ctl.cnt_calc) cnt_r <= 9'(cnt_sum);
    if (ctl.nth_calc) found_r <= nth_hit;
    if (ctl.item_calc) begin
      quo    <= cw.rank;
      rem    <= '0;
      walk_n <= 12'(n2);
      if (!stat.item_full && stat.item_one) found_r <= 1'b1;
    end
    if (ctl.div_step) begin
      rem <= div_ge ? 4'(div_t - {1'b0, max_fill}) : div_t[3:0];
      quo <= {quo[10:0], div_ge};
    end
    if (ctl.full_rd) begin
      found_r <= 1'b1;
      ipos_r  <= rem;
    end
    if (ctl.get) slot_r <= 8'(list_rd);
    if (ctl.wf_rd) walk_s <= list_rd;
    if (ctl.wc_step) begin
      if (stat.walk_hit) begin
        found_r <= 1'b1;
        slot_r  <= 8'(walk_s);
        ipos_r  <= walk_n[3:0];
      end else begin
        walk_n <= walk_n - 12'(fill_rd);
      end
    end
    if (ctl.finish) begin
      res <= '{found: found_r, result_slot: slot_r, item_position: ipos_r,
               range_count: cnt_r};
    end
  end

  assign stat.clr_last  = step == CTW'(NUM_SLOTS - 1);
  assign stat.is_insert = cw.kind == KIND_INSERT;
  assign stat.chk_last  = step == CTW'(4);
  assign stat.rem_ok    = slot_ok && (hold[bsel] || (bsel == BK_MULTI && chk_hit));
  assign stat.nth_hit   = nth_hit;
  assign stat.item_full = rk < full_items;
  assign stat.item_one  = n1 < NW'(size_q[BK_ONE]);
  assign stat.multi_any = size_q[BK_MULTI] != '0;
  assign stat.div_last  = step == CTW'(11);
  assign stat.walk_hit  = walk_n < 12'(fill_rd);
  assign stat.walk_last = (step + 1'b1) == CTW'(size_q[BK_MULTI]);
  assign stat.out_free  = !res_valid || !res_stall;
endmodule
`default_nettype wire

// ----- src/fill_level_bucketed_sparse_set.sv -----
// Fill-level bucketed sparse set: each slot sits in at most one of four buckets
// (empty, full, one, multi) kept as swap-remove member lists in on-chip RAM.
// After reset a clearing pass rebuilds the empty list; no word is taken
// then. One word is worked at a time, by a shared list RAM port. An nth
// item in the full bucket runs a 12-step divider, and a walk of the multi
// bucket reads the list, reads the fill and checks each member in turn.
// A result waits in an output register while the next word is taken.
// max_fill sits at byte address 0.
`default_nettype none
module fill_level_bucketed_sparse_set #(
  parameter int NUM_SLOTS = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_stall,
  input  wire flbss_pkg::cmd_word_t cmd,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output flbss_pkg::res_word_t      res,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import flbss_pkg::*;

  ctl_cmd_t   ctl;
  dp_stat_t   stat;
  logic [3:0] max_fill;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MAX_FILL) ? {28'd0, max_fill} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_fill <= MAX_FILL_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_FILL) begin
      max_fill <= pwdata[3:0];
    end
  end

  assign cmd_stall = !ctl.idle;

  flbss_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_kind(cmd.kind),
    .stat(stat), .ctl(ctl)
  );

  flbss_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .cmd(cmd), .max_fill(max_fill),
    .res_stall(res_stall), .res_valid(res_valid), .res(res), .stat(stat)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("word taken while another is in work");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    ctl.clr_step |-> cmd_stall)
    else $error("word taken during clearing pass");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> res_valid)
    else $error("finished result not presented");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Testbench for fill_level_bucketed_sparse_set: directed table, then random
// bucket moves and queries checked against an in-bench bucket predictor.
// Depends on flbss_pkg and the block's RTL only.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import flbss_pkg::*;

  localparam int SLOTS = 256;
  localparam int WD_LIMIT = 20000;
  localparam int SETTLE = 1000;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_word_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_word_t res;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  fill_level_bucketed_sparse_set i_dut (.*);

  always #6 clk = ~clk;

  // bucket predictor state
  logic [7:0] bucket_list [4][SLOTS];
  int member_pos [SLOTS];
  int bucket_size [4];
  int slot_fill [SLOTS];
  int full_fill;

  res_word_t pending_res [$];
  bit cur_fixed;
  res_word_t cur_res;
  int mismatches = 0;
  int idle_pct = 0, stall_pct = 0, hold_off = 0, quiet = 0;

  function automatic logic [1:0] bucket_for(int fill);
    if (fill == 0) return BK_EMPTY;
    if (fill == full_fill) return BK_FULL;
    if (fill == 1) return BK_ONE;
    return BK_MULTI;
  endfunction

  function automatic bit holds(int b, int s);
    return member_pos[s] < bucket_size[b] && bucket_list[b][member_pos[s]] == s;
  endfunction

  function automatic int bucket_of(int s);
    for (int b = 0; b < 4; b++) if (holds(b, s)) return b;
    return -1;
  endfunction

  function automatic res_word_t predict(cmd_word_t c);
    res_word_t r;
    bit inc [4];
    int b, pos, last, sel, n, cnt, sf, full_items;
    bit done;
    r = '0;
    inc[BK_EMPTY] = c.size_lo <= c.size_hi && c.size_lo == 0;
    inc[BK_FULL]  = c.size_lo <= c.size_hi && c.size_hi >= full_fill;
    inc[BK_ONE]   = c.size_lo <= c.size_hi && c.size_lo <= 1 && c.size_hi >= 1
                    && full_fill != 1;
    inc[BK_MULTI] = c.size_lo <= c.size_hi && c.size_lo <= 2 && c.size_hi >= 2
                    && full_fill > 2;
    case (c.kind)
      KIND_INSERT: begin
        if (bucket_of(c.slot_id) < 0) begin
          b = bucket_for(c.fill_count);
          if (bucket_size[b] < SLOTS) begin
            bucket_list[b][bucket_size[b]] = c.slot_id;
            member_pos[c.slot_id] = bucket_size[b];
            bucket_size[b]++;
            slot_fill[c.slot_id] = c.fill_count;
          end
        end
      end
      KIND_REMOVE: begin
        b = bucket_for(c.fill_count);
        if (holds(b, c.slot_id)) begin
          pos = member_pos[c.slot_id];
          last = bucket_list[b][bucket_size[b] - 1];
          bucket_list[b][pos] = 8'(last);
          member_pos[last] = pos;
          bucket_size[b]--;
        end
      end
      KIND_COUNT: begin
        cnt = 0;
        for (b = 0; b < 4; b++) if (inc[b]) cnt += bucket_size[b];
        r.range_count = cnt[8:0];
      end
      KIND_NTH_SLOT: begin
        sel = c.rank;
        done = 0;
        for (b = 0; b < 4; b++) begin
          if (inc[b] && !done) begin
            if (sel < bucket_size[b]) begin
              r.found = 1'b1;
              r.result_slot = bucket_list[b][sel];
              done = 1;
            end else begin
              sel -= bucket_size[b];
            end
          end
        end
      end
      KIND_NTH_ITEM: begin
        n = c.rank;
        full_items = bucket_size[BK_FULL] * full_fill;
        if (n < full_items) begin
          r.found = 1'b1;
          r.result_slot = bucket_list[BK_FULL][n / full_fill];
          r.item_position = 4'(n % full_fill);
        end else begin
          n -= full_items;
          if (n < bucket_size[BK_ONE]) begin
            r.found = 1'b1;
            r.result_slot = bucket_list[BK_ONE][n];
          end else begin
            n -= bucket_size[BK_ONE];
            done = 0;
            for (int i = 0; i < bucket_size[BK_MULTI]; i++) begin
              sf = slot_fill[bucket_list[BK_MULTI][i]];
              if (!done) begin
                if (n < sf) begin
                  r.found = 1'b1;
                  r.result_slot = bucket_list[BK_MULTI][i];
                  r.item_position = 4'(n);
                  done = 1;
                end else begin
                  n -= sf;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // check results, predict accepted words, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      res_word_t want;
      if (res_valid && !res_stall) begin
        if (pending_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", res);
        end else begin
          want = pending_res.pop_front();
          if (res.found !== want.found || res.result_slot !== want.result_slot ||
              res.item_position !== want.item_position ||
              res.range_count !== want.range_count) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, res);
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        want = predict(cmd);
        pending_res.push_back(cur_fixed ? cur_res : want);
      end
      if ((res_valid && !res_stall) || (cmd_valid && !cmd_stall)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
        if (quiet >= WD_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (hold_off > 0) begin
      res_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      res_stall <= ($urandom % 100) < stall_pct;
    end
  end

  task automatic send(cmd_word_t w, bit fixed = 0, res_word_t r = '0);
    while (($urandom % 100) < idle_pct) begin
      cmd_valid = 1'b0;
      @(negedge clk);
    end
    cmd_valid = 1'b1;
    cmd = w;
    cur_fixed = fixed;
    cur_res = r;
    do @(posedge clk); while (!(cmd_valid && !cmd_stall));
    @(negedge clk);
  endtask

  task automatic drain();
    cmd_valid = 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_max_fill(logic [3:0] v);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = ADDR_MAX_FILL; pwdata = {28'd0, v};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    full_fill = v;
  endtask

  function automatic cmd_word_t word(logic [2:0] k, int s = 0, int f = 0,
                                     int lo = 0, int hi = 15, int rk = 0);
    cmd_word_t w;
    w.kind = k; w.slot_id = 8'(s); w.fill_count = 4'(f);
    w.size_lo = 4'(lo); w.size_hi = 4'(hi); w.rank = 12'(rk);
    return w;
  endfunction

  function automatic res_word_t hit(bit f, int s, int cnt);
    res_word_t r;
    r = '0; r.found = f; r.result_slot = 8'(s); r.range_count = 9'(cnt);
    return r;
  endfunction

  function automatic int fill_in(int b);
    int f;
    case (b)
      BK_EMPTY: return 0;
      BK_FULL:  return full_fill;
      BK_ONE:   return 1;
      default: begin
        do f = $urandom_range(2, 15); while (f == full_fill);
        return f;
      end
    endcase
  endfunction

  function automatic cmd_word_t noisy(cmd_word_t w);
    cmd_word_t n;
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    n = bits[$bits(cmd_word_t)-1:0];
    if (w.kind != KIND_COUNT && w.kind != KIND_NTH_SLOT) begin
      w.size_lo = n.size_lo; w.size_hi = n.size_hi;
    end
    if (w.kind == KIND_INSERT || w.kind == KIND_REMOVE || w.kind == KIND_COUNT)
      w.rank = n.rank;
    if (w.kind > KIND_REMOVE) begin
      w.slot_id = n.slot_id; w.fill_count = n.fill_count;
    end
    return w;
  endfunction

  typedef struct {
    cmd_word_t w;
    bit fixed;
    res_word_t r;
  } row_t;

  row_t plan [$];
  res_word_t none;
  int s, b, f, pick, total;
  int fills [7] = '{1, 15, 0, 2, 3, 7, 4};

  initial begin
    none = '0;
    full_fill = MAX_FILL_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      bucket_list[BK_EMPTY][i] = 8'(i);
      member_pos[i] = i;
      slot_fill[i] = 0;
    end
    bucket_size = '{SLOTS, 0, 0, 0};
    repeat (7) @(negedge clk);
    rst = 1'b0;

    plan = '{
      '{word(KIND_COUNT, 0, 0, 0, 15), 1, hit(0, 0, 256)},
      '{word(KIND_COUNT, 0, 0, 5, 3), 1, none},
      '{word(KIND_NTH_SLOT, 0, 0, 0, 0, 0), 1, hit(1, 0, 0)},
      '{word(KIND_NTH_SLOT, 0, 0, 0, 15, 255), 1, hit(1, 255, 0)},
      '{word(KIND_NTH_SLOT, 0, 0, 0, 15, 256), 1, none},
      '{word(KIND_NTH_SLOT, 0, 0, 9, 2, 0), 1, none},
      '{word(KIND_NTH_ITEM, 0, 0, 0, 15, 0), 1, none},
      '{word(KIND_INSERT, 3, 2), 1, none},
      '{word(KIND_SPARE_LO, 255, 15, 15, 15, 4095), 1, none},
      '{word(KIND_SPARE_HI), 1, none},
      '{word(KIND_REMOVE, 0, 0), 1, none},
      '{word(KIND_INSERT, 0, 4), 1, none},
      '{word(KIND_REMOVE, 255, 0), 1, none},
      '{word(KIND_INSERT, 255, 1), 1, none},
      '{word(KIND_REMOVE, 128, 0), 1, none},
      '{word(KIND_INSERT, 128, 15), 1, none},
      '{word(KIND_REMOVE, 7, 5), 1, none},
      '{word(KIND_NTH_ITEM, 0, 0, 0, 15, 3), 0, none},
      '{word(KIND_NTH_ITEM, 0, 0, 0, 15, 4), 0, none},
      '{word(KIND_NTH_ITEM, 0, 0, 0, 15, 19), 0, none},
      '{word(KIND_NTH_ITEM, 0, 0, 0, 15, 4095), 0, none},
      '{word(KIND_COUNT, 0, 0, 1, 1), 0, none},
      '{word(KIND_NTH_SLOT, 0, 0, 1, 15, 1), 0, none},
      '{word(KIND_REMOVE, 0, 4), 0, none},
      '{word(KIND_NTH_SLOT, 0, 0, 0, 0, 0), 0, none}
    };
    foreach (plan[i]) send(plan[i].w, plan[i].fixed, plan[i].r);
    drain();

    foreach (fills[ph]) begin
      write_max_fill(4'(fills[ph]));
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      if (ph == 1) hold_off = 3000;
      for (int n = 0; n < 150; n++) begin
        if (n == 75 && ph == 4) drain();
        pick = $urandom % 100;
        s = $urandom % SLOTS;
        b = bucket_of(s);
        total = bucket_size[BK_FULL] * full_fill + bucket_size[BK_ONE];
        for (int i = 0; i < bucket_size[BK_MULTI]; i++)
          total += slot_fill[bucket_list[BK_MULTI][i]];
        if (pick < 35) begin
          if (b >= 0) send(noisy(word(KIND_REMOVE, s, fill_in(b))));
          case ($urandom % 4)
            0: f = 0;
            1: f = 1;
            2: f = full_fill;
            default: f = $urandom % 16;
          endcase
          send(noisy(word(KIND_INSERT, s, f)));
        end else if (pick < 40) begin
          if (b >= 0) send(noisy(word(KIND_REMOVE, s, fill_in(b))));
        end else if (pick < 47) begin
          send(noisy(word(($urandom % 2) ? KIND_INSERT : KIND_REMOVE, s, $urandom % 16)));
        end else if (pick < 62) begin
          send(noisy(word(KIND_COUNT, 0, 0, $urandom % 16, $urandom % 16)));
        end else if (pick < 77) begin
          send(noisy(word(KIND_NTH_SLOT, 0, 0, $urandom % 4, $urandom % 16,
                          ($urandom % 8) ? $urandom % 300 : $urandom % 4096)));
        end else if (pick < 95) begin
          send(noisy(word(KIND_NTH_ITEM, 0, 0, 0, 0,
                          ($urandom % 8) ? $urandom % (total + 20) : $urandom % 4096)));
        end else begin
          send(noisy(word(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)))));
        end
      end
      drain();
    end

    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
